### hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types, widths and constants of the pure pursuit steering pipeline.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int DX_W  = 18;   // target x minus pose x
  localparam int DY_W  = 22;   // target y plus row offset minus pose y
  localparam int BW    = 36;   // bearing CORDIC x/y
  localparam int SW    = 34;   // sine CORDIC x/y/z
  localparam int QW    = 16;   // angular quotient bits, one divide stage each
  localparam int CFG_ADDR_W = 3;

  localparam logic signed [SW-1:0] SIN_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET_X  = 3'd0,
    REG_TARGET_Y  = 3'd1,
    REG_LIN_VEL   = 3'd2,
    REG_LOOKAHEAD = 3'd3,
    REG_ROW_SPACE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [BW-1:0] x;
    logic signed [BW-1:0] y;
    logic [31:0]          z;
    logic [15:0]          th;
    logic                 moving;
  } brg_t;

  typedef struct packed {
    logic [15:0] err;
    logic        moving;
  } err_t;

  typedef struct packed {
    logic signed [SW-1:0] s;
    logic                 moving;
  } sin_t;

  typedef struct packed {
    logic [14:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               moving;
  } cmd_t;

endpackage

### hdl/pps_ifs.sv
// ----------------------------------------------------------------------------
// pps channel interfaces
// Pose input, command output and register write channels.
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         robot_index;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic [15:0]        pose_theta;

  modport source (output valid, robot_index, pose_x, pose_y, pose_theta, input ready);
  modport sink   (input valid, robot_index, pose_x, pose_y, pose_theta, output ready);
endinterface

interface pps_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        linear_cmd;
  logic signed [15:0] angular_cmd;
  logic               moving;

  modport source (output valid, linear_cmd, angular_cmd, moving, input ready);
  modport sink   (input valid, linear_cmd, angular_cmd, moving, output ready);
endinterface

interface pps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### hdl/pps_front.sv
// ----------------------------------------------------------------------------
// pps_front
// Goal offset, pose delta, distance test and CORDIC pre-rotation (4 stages).
// ----------------------------------------------------------------------------
module pps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [3:0]          robot_index,
  input  logic signed [15:0]  pose_x,
  input  logic signed [15:0]  pose_y,
  input  logic [15:0]         pose_theta,
  input  logic signed [15:0]  target_x,
  input  logic signed [15:0]  target_y,
  input  logic signed [15:0]  row_spacing,
  input  logic [14:0]         lookahead,
  output logic                out_valid,
  output pps_pkg::brg_t       out_data
);
  import pps_pkg::*;

  // stage 1: row offset
  logic               v1_r;
  logic signed [21:0] off1_r;
  logic signed [15:0] px1_r, py1_r;
  logic [15:0]        th1_r;
  logic signed [5:0]  idxm1;
  logic signed [21:0] off;

  // stage 2: deltas
  logic                  v2_r;
  logic signed [DX_W-1:0] dx2_r;
  logic signed [DY_W-1:0] dy2_r;
  logic [15:0]            th2_r;

  // stage 3: squares and pre-rotation
  logic                   v3_r;
  logic [34:0]            dxsq3_r;
  logic [42:0]            dysq3_r;
  logic [29:0]            ld2_3_r;
  logic signed [BW-1:0]   x3_r, y3_r;
  logic [31:0]            z3_r;
  logic [15:0]            th3_r;
  logic signed [35:0]     dxsq;
  logic signed [43:0]     dysq;
  logic signed [BW-1:0]   xs, ys;

  // stage 4: compare
  logic  v4_r;
  brg_t  d4_r;
  logic [43:0] dist2;

  assign idxm1 = $signed({2'b00, robot_index}) - 6'sd1;
  assign off   = row_spacing * idxm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign dxsq = dx2_r * dx2_r;
  assign dysq = dy2_r * dy2_r;
  assign xs   = BW'(dx2_r) <<< 10;
  assign ys   = BW'(dy2_r) <<< 10;
  assign dist2 = 44'(dxsq3_r) + 44'(dysq3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      off1_r <= off;
      px1_r  <= pose_x;
      py1_r  <= pose_y;
      th1_r  <= pose_theta;

      dx2_r  <= DX_W'(target_x) - DX_W'(px1_r);
      dy2_r  <= DY_W'(target_y) + DY_W'(off1_r) - DY_W'(py1_r);
      th2_r  <= th1_r;

      dxsq3_r <= dxsq[34:0];
      dysq3_r <= dysq[42:0];
      ld2_3_r <= lookahead * lookahead;
      th3_r   <= th2_r;
      // half-turn pre-rotation keeps the vector in the right half plane
      if (dx2_r < 0) begin
        x3_r <= -xs;
        y3_r <= -ys;
        z3_r <= 32'h8000_0000;
      end else begin
        x3_r <= xs;
        y3_r <= ys;
        z3_r <= 32'h0000_0000;
      end

      d4_r.x      <= x3_r;
      d4_r.y      <= y3_r;
      d4_r.z      <= z3_r;
      d4_r.th     <= th3_r;
      d4_r.moving <= (dist2 > 44'(ld2_3_r));
    end
  end

  assign out_valid = v4_r;
  assign out_data  = d4_r;

endmodule

### hdl/pps_brg_cordic.sv
// ----------------------------------------------------------------------------
// pps_brg_cordic
// Vectoring CORDIC atan2, one iteration per stage, then heading error.
// ----------------------------------------------------------------------------
module pps_brg_cordic (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pps_pkg::brg_t  in_data,
  output logic           out_valid,
  output pps_pkg::err_t  out_data
);
  import pps_pkg::*;

  logic                 vs [0:CORDIC_STEPS];
  logic signed [BW-1:0] xs [0:CORDIC_STEPS];
  logic signed [BW-1:0] ys [0:CORDIC_STEPS];
  logic [31:0]          zs [0:CORDIC_STEPS];
  logic [15:0]          ts [0:CORDIC_STEPS];
  logic                 ms [0:CORDIC_STEPS];

  logic                 v_r [0:CORDIC_STEPS-1];
  logic signed [BW-1:0] x_r [0:CORDIC_STEPS-1];
  logic signed [BW-1:0] y_r [0:CORDIC_STEPS-1];
  logic [31:0]          z_r [0:CORDIC_STEPS-1];
  logic [15:0]          t_r [0:CORDIC_STEPS-1];
  logic                 m_r [0:CORDIC_STEPS-1];

  logic        ve_r;
  err_t        e_r;
  logic [31:0] zround;

  assign vs[0] = in_valid;
  assign xs[0] = in_data.x;
  assign ys[0] = in_data.y;
  assign zs[0] = in_data.z;
  assign ts[0] = in_data.th;
  assign ms[0] = in_data.moving;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] > 0) begin
          x_r[i] <= xs[i] + (ys[i] >>> i);
          y_r[i] <= ys[i] - (xs[i] >>> i);
          z_r[i] <= zs[i] + ATAN_TAB[i];
        end else begin
          x_r[i] <= xs[i] - (ys[i] >>> i);
          y_r[i] <= ys[i] + (xs[i] >>> i);
          z_r[i] <= zs[i] - ATAN_TAB[i];
        end
        t_r[i] <= ts[i];
        m_r[i] <= ms[i];
      end
    end

    assign vs[i+1] = v_r[i];
    assign xs[i+1] = x_r[i];
    assign ys[i+1] = y_r[i];
    assign zs[i+1] = z_r[i];
    assign ts[i+1] = t_r[i];
    assign ms[i+1] = m_r[i];
  end

  // round angle to 16 bits, subtract heading (mod 2^16)
  assign zround = zs[CORDIC_STEPS] + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vs[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r.err    <= zround[31:16] - ts[CORDIC_STEPS];
      e_r.moving <= ms[CORDIC_STEPS];
    end
  end

  assign out_valid = ve_r;
  assign out_data  = e_r;

endmodule

### hdl/pps_sin_cordic.sv
// ----------------------------------------------------------------------------
// pps_sin_cordic
// Quadrant fold and rotation CORDIC sine, one iteration per stage.
// ----------------------------------------------------------------------------
module pps_sin_cordic (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pps_pkg::err_t  in_data,
  output logic           out_valid,
  output pps_pkg::sin_t  out_data
);
  import pps_pkg::*;

  logic                 vs [0:CORDIC_STEPS];
  logic signed [SW-1:0] xs [0:CORDIC_STEPS];
  logic signed [SW-1:0] ys [0:CORDIC_STEPS];
  logic signed [SW-1:0] zs [0:CORDIC_STEPS];
  logic                 ms [0:CORDIC_STEPS];

  logic                 v_r [0:CORDIC_STEPS-1];
  logic signed [SW-1:0] x_r [0:CORDIC_STEPS-1];
  logic signed [SW-1:0] y_r [0:CORDIC_STEPS-1];
  logic signed [SW-1:0] z_r [0:CORDIC_STEPS-1];
  logic                 m_r [0:CORDIC_STEPS-1];

  logic                 vf_r;
  logic signed [SW-1:0] zf_r;
  logic                 mf_r;
  logic [31:0]          a_raw, a_fold;

  // fold into [-pi/2, pi/2]: a -> pi - a
  assign a_raw  = {in_data.err, 16'h0000};
  assign a_fold = (a_raw > 32'h4000_0000 && a_raw < 32'hC000_0000) ?
                  (32'h8000_0000 - a_raw) : a_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r <= SW'($signed(a_fold));
      mf_r <= in_data.moving;
    end
  end

  assign vs[0] = vf_r;
  assign xs[0] = SIN_GAIN;
  assign ys[0] = '0;
  assign zs[0] = zf_r;
  assign ms[0] = mf_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          x_r[i] <= xs[i] - (ys[i] >>> i);
          y_r[i] <= ys[i] + (xs[i] >>> i);
          z_r[i] <= zs[i] - SW'(ATAN_TAB[i]);
        end else begin
          x_r[i] <= xs[i] + (ys[i] >>> i);
          y_r[i] <= ys[i] - (xs[i] >>> i);
          z_r[i] <= zs[i] + SW'(ATAN_TAB[i]);
        end
        m_r[i] <= ms[i];
      end
    end

    assign vs[i+1] = v_r[i];
    assign xs[i+1] = x_r[i];
    assign ys[i+1] = y_r[i];
    assign zs[i+1] = z_r[i];
    assign ms[i+1] = m_r[i];
  end

  assign out_valid       = vs[CORDIC_STEPS];
  assign out_data.s      = ys[CORDIC_STEPS];
  assign out_data.moving = ms[CORDIC_STEPS];

endmodule

### hdl/pps_angular.sv
// ----------------------------------------------------------------------------
// pps_angular
// Angular rate v*|sin|/L with rounding, pipelined restoring divide, saturate.
// ----------------------------------------------------------------------------
module pps_angular (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pps_pkg::sin_t  in_data,
  input  logic [14:0]    velocity,
  input  logic [14:0]    lookahead,
  output logic           out_valid,
  output pps_pkg::cmd_t  out_data
);
  import pps_pkg::*;

  // stage A: product
  logic        va_r, pa_r, ma_r;
  logic [46:0] prod_r;
  logic [31:0] mag;

  // stage B: add half divisor, drop 2^17
  logic        vb_r, pb_r, mb_r;
  logic [30:0] num_r;
  logic [47:0] sum;

  // divide stages; index 0 is the setup register
  logic          vs [0:QW];
  logic [14:0]   rs [0:QW];
  logic [QW-1:0] ls [0:QW];
  logic [QW-1:0] qs [0:QW];
  logic          os [0:QW];
  logic          ps [0:QW];
  logic          ms [0:QW];

  logic          v_r [0:QW];
  logic [14:0]   r_r [0:QW];
  logic [QW-1:0] l_r [0:QW];
  logic [QW-1:0] q_r [0:QW];
  logic          o_r [0:QW];
  logic          p_r [0:QW];
  logic          m_r [0:QW];

  logic        vo_r;
  cmd_t        c_r;
  logic signed [16:0] negq;
  logic signed [15:0] ang;

  assign mag = in_data.s[SW-1] ? 32'(-in_data.s) : 32'(in_data.s);
  assign sum = 48'(prod_r) + {17'd0, lookahead, 16'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= velocity * mag;
      pa_r   <= (in_data.s > 0);
      ma_r   <= in_data.moving;
      num_r  <= sum[47:17];
      pb_r   <= pa_r;
      mb_r   <= ma_r;
    end
  end

  // setup: overflow means the quotient needs more than 16 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= num_r[30:16];
      l_r[0] <= num_r[15:0];
      q_r[0] <= '0;
      o_r[0] <= (num_r >= {lookahead, 16'd0});
      p_r[0] <= pb_r;
      m_r[0] <= mb_r;
    end
  end

  assign vs[0] = v_r[0];
  assign rs[0] = r_r[0];
  assign ls[0] = l_r[0];
  assign qs[0] = q_r[0];
  assign os[0] = o_r[0];
  assign ps[0] = p_r[0];
  assign ms[0] = m_r[0];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [15:0] trial;
    assign trial = {rs[k], ls[k][QW-1-k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, lookahead}) begin
          r_r[k+1] <= 15'(trial - {1'b0, lookahead});
          q_r[k+1] <= qs[k] | (QW'(1) << (QW-1-k));
        end else begin
          r_r[k+1] <= trial[14:0];
          q_r[k+1] <= qs[k];
        end
        l_r[k+1] <= ls[k];
        o_r[k+1] <= os[k];
        p_r[k+1] <= ps[k];
        m_r[k+1] <= ms[k];
      end
    end

    assign vs[k+1] = v_r[k+1];
    assign rs[k+1] = r_r[k+1];
    assign ls[k+1] = l_r[k+1];
    assign qs[k+1] = q_r[k+1];
    assign os[k+1] = o_r[k+1];
    assign ps[k+1] = p_r[k+1];
    assign ms[k+1] = m_r[k+1];
  end

  // sign opposite to sin; saturate to 16 bits
  assign negq = -$signed({1'b0, qs[QW]});

  always_comb begin
    if (ps[QW]) begin
      if (os[QW] || qs[QW] > 16'd32768) begin
        ang = 16'sh8000;
      end else begin
        ang = negq[15:0];
      end
    end else begin
      if (os[QW] || qs[QW][15]) begin
        ang = 16'sh7FFF;
      end else begin
        ang = $signed(qs[QW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vs[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r.linear_cmd  <= ms[QW] ? velocity : 15'd0;
      c_r.angular_cmd <= ms[QW] ? ang : 16'sd0;
      c_r.moving      <= ms[QW];
    end
  end

  assign out_valid = vo_r;
  assign out_data  = c_r;

endmodule

### hdl/pure_pursuit_steering_step.sv
// Pipeline stages from input transfer to result transfer: 4 front, 25 atan2,
//   25 sine, 20 multiply/divide/saturate; one pose per cycle unless the result stalls.
// The whole pipeline advances when the output register is empty or taken;
//   a stalled result holds every stage.
// Reset (synchronous, rst_n low) clears all stage valid bits and loads the
//   register defaults; config writes are always accepted.
// ----------------------------------------------------------------------------
// pure_pursuit_steering_step
// Pure pursuit steering: pose to goal bearing, heading error, turn command.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_step (
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch,
  pps_cfg_if.sink   cfg_ch
);
  import pps_pkg::*;

  logic signed [15:0] target_x_r, target_y_r, row_spacing_r;
  logic [14:0]        lin_vel_r, lookahead_r;
  logic [14:0]        ld_eff;
  logic               en;

  logic  f_valid, b_valid, s_valid, a_valid;
  brg_t  f_data;
  err_t  b_data;
  sin_t  s_data;
  cmd_t  a_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r    <= 16'sd0;
      target_y_r    <= 16'sd0;
      lin_vel_r     <= 15'd614;
      lookahead_r   <= 15'd492;
      row_spacing_r <= 16'sd2048;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_TARGET_X:  target_x_r    <= cfg_ch.data;
        REG_TARGET_Y:  target_y_r    <= cfg_ch.data;
        REG_LIN_VEL:   lin_vel_r     <= cfg_ch.data[14:0];
        REG_LOOKAHEAD: lookahead_r   <= cfg_ch.data[14:0];
        REG_ROW_SPACE: row_spacing_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // zero look-ahead acts as one
  assign ld_eff = (lookahead_r == 15'd0) ? 15'd1 : lookahead_r;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  pps_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_ch.valid),
    .robot_index (in_ch.robot_index),
    .pose_x      (in_ch.pose_x),
    .pose_y      (in_ch.pose_y),
    .pose_theta  (in_ch.pose_theta),
    .target_x    (target_x_r),
    .target_y    (target_y_r),
    .row_spacing (row_spacing_r),
    .lookahead   (ld_eff),
    .out_valid   (f_valid),
    .out_data    (f_data)
  );

  pps_brg_cordic u_brg (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_data  (b_data)
  );

  pps_sin_cordic u_sin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid),
    .in_data   (b_data),
    .out_valid (s_valid),
    .out_data  (s_data)
  );

  pps_angular u_ang (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_data   (s_data),
    .velocity  (lin_vel_r),
    .lookahead (ld_eff),
    .out_valid (a_valid),
    .out_data  (a_data)
  );

  assign out_ch.valid       = a_valid;
  assign out_ch.linear_cmd  = a_data.linear_cmd;
  assign out_ch.angular_cmd = a_data.angular_cmd;
  assign out_ch.moving      = a_data.moving;

endmodule

### hdl/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks on the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] linear_cmd,
  input logic [15:0] angular_cmd,
  input logic        moving,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // arrived robots get no speed and no turn
  `PPS_ASSERT(a_stop_lin, out_valid && !moving |-> linear_cmd == 15'd0, "linear_cmd set while stopped")
  `PPS_ASSERT(a_stop_ang, out_valid && !moving |-> angular_cmd == 16'd0, "angular_cmd set while stopped")
  // a stalled result holds
  `PPS_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(angular_cmd) && $stable(linear_cmd) && $stable(moving), "stalled result changed")
  `PPS_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result valid right after reset")
  `PPS_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "register write refused")

endmodule

bind pure_pursuit_steering_step pps_checker u_pps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .linear_cmd  (out_ch.linear_cmd),
  .angular_cmd (out_ch.angular_cmd),
  .moving      (out_ch.moving),
  .cfg_valid   (cfg_ch.valid),
  .cfg_ready   (cfg_ch.ready)
);
